### rtl/mcmb_pkg.sv
`timescale 1ns / 1ps

package mcmb_pkg;

   // Sizing
   localparam int CHANNELS = 8;
   localparam int MSG_LEN  = 256;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W    = $clog2(CHANNELS + 1);
   localparam int POS_W    = $clog2(MSG_LEN);
   localparam int MEM_AW   = CH_W + POS_W;
   localparam int MEM_DEPTH = 1 << MEM_AW;

   // Fixed field widths
   localparam int PIN_W    = 8;
   localparam int CHAR_W   = 8;
   localparam int CNTDN_W  = 8;
   localparam int ELEM_W   = 3;
   localparam int ENT_W    = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Table entries
   localparam logic [ENT_W-1:0] SPACE_ENTRY = ENT_W'(26);
   localparam logic [ENT_W-1:0] DIGIT_BASE  = ENT_W'(27);

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_TICK    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE     = 3'd0,
      CSR_DOT        = 3'd1,
      CSR_DASH       = 3'd2,
      CSR_SYMBOL_GAP = 3'd3,
      CSR_LETTER_GAP = 3'd4,
      CSR_WORD_GAP   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [6:0] dot_ticks;
      logic [6:0] dash_ticks;
      logic [7:0] symbol_gap_ticks;
      logic [7:0] letter_gap_ticks;
      logic [7:0] word_gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CNTDN_W-1:0] countdown;
      logic [ELEM_W-1:0]  elem;
      logic [POS_W-1:0]   pos;
      logic               pin_write;
      logic               pin_level;
   } chan_next_type;

   // ASCII to table entry; anything unknown keys as a space
   function automatic logic [ENT_W-1:0] table_entry(input logic [CHAR_W-1:0] c);
      logic [ENT_W-1:0] ent;
      if (c >= 8'h61 && c <= 8'h7a) begin
         ent = ENT_W'(c - 8'h61);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         ent = ENT_W'(c - 8'h30) + DIGIT_BASE;
      end else begin
         ent = SPACE_ENTRY;
      end
      return ent;
   endfunction

   // Number of elements per entry
   function automatic logic [2:0] code_len(input logic [ENT_W-1:0] ent);
      logic [2:0] len;
      case (ent)
         6'd0:  len = 3'd2;
         6'd1:  len = 3'd4;
         6'd2:  len = 3'd4;
         6'd3:  len = 3'd3;
         6'd4:  len = 3'd1;
         6'd5:  len = 3'd4;
         6'd6:  len = 3'd3;
         6'd7:  len = 3'd4;
         6'd8:  len = 3'd2;
         6'd9:  len = 3'd4;
         6'd10: len = 3'd3;
         6'd11: len = 3'd4;
         6'd12: len = 3'd2;
         6'd13: len = 3'd2;
         6'd14: len = 3'd3;
         6'd15: len = 3'd4;
         6'd16: len = 3'd4;
         6'd17: len = 3'd3;
         6'd18: len = 3'd3;
         6'd19: len = 3'd1;
         6'd20: len = 3'd3;
         6'd21: len = 3'd4;
         6'd22: len = 3'd3;
         6'd23: len = 3'd4;
         6'd24: len = 3'd4;
         6'd25: len = 3'd4;
         6'd26: len = 3'd1;
         default: len = 3'd5;
      endcase
      return len;
   endfunction

   // Bit e set: element e is a dash
   function automatic logic [7:0] code_bits(input logic [ENT_W-1:0] ent);
      logic [7:0] bits;
      case (ent)
         6'd0:  bits = 8'h02;
         6'd1:  bits = 8'h01;
         6'd2:  bits = 8'h05;
         6'd3:  bits = 8'h01;
         6'd4:  bits = 8'h00;
         6'd5:  bits = 8'h04;
         6'd6:  bits = 8'h03;
         6'd7:  bits = 8'h00;
         6'd8:  bits = 8'h00;
         6'd9:  bits = 8'h0E;
         6'd10: bits = 8'h05;
         6'd11: bits = 8'h02;
         6'd12: bits = 8'h03;
         6'd13: bits = 8'h01;
         6'd14: bits = 8'h07;
         6'd15: bits = 8'h06;
         6'd16: bits = 8'h0B;
         6'd17: bits = 8'h02;
         6'd18: bits = 8'h00;
         6'd19: bits = 8'h01;
         6'd20: bits = 8'h04;
         6'd21: bits = 8'h08;
         6'd22: bits = 8'h06;
         6'd23: bits = 8'h09;
         6'd24: bits = 8'h0D;
         6'd25: bits = 8'h03;
         6'd26: bits = 8'h00;
         6'd27: bits = 8'h1F;
         6'd28: bits = 8'h1E;
         6'd29: bits = 8'h1C;
         6'd30: bits = 8'h18;
         6'd31: bits = 8'h10;
         6'd32: bits = 8'h00;
         6'd33: bits = 8'h01;
         6'd34: bits = 8'h03;
         6'd35: bits = 8'h07;
         6'd36: bits = 8'h0F;
         default: bits = 8'h00;
      endcase
      return bits;
   endfunction

endpackage

### rtl/multi_channel_morse_beacon_top.sv
`timescale 1ns / 1ps

// Response: write, restart, unused ops and a tick with no active channel answer
//   in the cycle after acceptance; a tick with N = active (1..8) runs READ then
//   UPDATE for each channel through the shared channel update unit and the
//   registered message RAM read, then DONE. One request is taken at a time.
// Reset (synchronous, active high) clears positions, element indexes,
//   countdowns, pins and loads the register defaults; message RAM is not cleared.
module multi_channel_morse_beacon_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_op,
   input  logic [2:0]                     req_channel,
   input  logic [7:0]                     req_address,
   input  logic [7:0]                     req_character,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_pins,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mcmb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mcmb_pkg::CSR_DATA_W-1:0] csr_data
);
   import mcmb_pkg::*;

   // One-hot sequencer: IDLE takes a request; READ presents the message
   // address of the current channel; UPDATE runs the shared channel unit on
   // the returned character; DONE posts the pin vector once the output
   // register is free.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Registers
   logic [3:0]  active_ff;
   cfg_type     cfg_ff;

   // Per-channel state, indexed by the sequencer's channel counter
   logic [POS_W-1:0]   pos_ff   [CHANNELS];
   logic [POS_W-1:0]   pos_in   [CHANNELS];
   logic [ELEM_W-1:0]  elem_ff  [CHANNELS];
   logic [ELEM_W-1:0]  elem_in  [CHANNELS];
   logic [CNTDN_W-1:0] cntdn_ff [CHANNELS];
   logic [CNTDN_W-1:0] cntdn_in [CHANNELS];
   logic [PIN_W-1:0]   pins_ff, pins_in;

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CH_W-1:0]    ch_sel;
   logic [CNT_W-1:0]   n_active;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIN_W-1:0]   rsp_pins_ff, rsp_pins_in;
   logic               out_free;
   logic               req_accept;

   // Message RAM port
   logic               ram_we;
   logic [MEM_AW-1:0]  ram_addr;
   logic [CHAR_W-1:0]  ram_rdata;

   chan_next_type      nxt;

   assign ch_sel     = cnt_ff[CH_W-1:0];
   assign n_active   = (32'(active_ff) > CHANNELS) ? CNT_W'(CHANNELS) : CNT_W'(active_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pins   = rsp_pins_ff;

   mcmb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MEM_DEPTH)
   ) u_msg_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_character),
      .rdata (ram_rdata)
   );

   // Shared update unit, one channel per UPDATE cycle
   mcmb_chan_unit u_chan_unit (
      .countdown (cntdn_ff[ch_sel]),
      .elem      (elem_ff[ch_sel]),
      .pos       (pos_ff[ch_sel]),
      .chr       (ram_rdata),
      .cfg       (cfg_ff),
      .nxt       (nxt)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      elem_in      = elem_ff;
      cntdn_in     = cntdn_ff;
      pins_in      = pins_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pins_in  = rsp_pins_ff;
      ram_we       = 1'b0;
      ram_addr     = {ch_sel, pos_ff[ch_sel]};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (op_type'(req_op))
                  OP_WRITE: begin
                     // out-of-range locations are dropped
                     if ((32'(req_channel) < CHANNELS) && (32'(req_address) < MSG_LEN)) begin
                        ram_we   = 1'b1;
                        ram_addr = {CH_W'(req_channel), POS_W'(req_address)};
                     end
                     rsp_valid_in = 1'b1;
                     rsp_pins_in  = pins_ff;
                  end
                  OP_TICK: begin
                     if (n_active == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_pins_in  = pins_ff;
                     end else begin
                        cnt_in   = '0;
                        state_in = ST_READ;
                     end
                  end
                  OP_RESTART: begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        pos_in[i]   = '0;
                        elem_in[i]  = '0;
                        cntdn_in[i] = '0;
                     end
                     pins_in      = '0;
                     rsp_valid_in = 1'b1;
                     rsp_pins_in  = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_pins_in  = pins_ff;
                  end
               endcase
            end
         end
         ST_READ: begin
            // address already on the RAM port; data arrives next cycle
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cntdn_in[ch_sel] = nxt.countdown;
            elem_in[ch_sel]  = nxt.elem;
            pos_in[ch_sel]   = nxt.pos;
            if (nxt.pin_write) begin
               pins_in[ch_sel] = nxt.pin_level;
            end
            if (CNT_W'(cnt_ff + CNT_W'(1)) == n_active) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = CNT_W'(cnt_ff + CNT_W'(1));
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pins_in  = pins_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pins_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            pos_ff[i]   <= '0;
            elem_ff[i]  <= '0;
            cntdn_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pins_ff      <= pins_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         elem_ff      <= elem_in;
         cntdn_ff     <= cntdn_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pins_ff <= rsp_pins_in;
   end

   // Register file; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff               <= 4'd0;
         cfg_ff.dot_ticks        <= 7'd1;
         cfg_ff.dash_ticks       <= 7'd3;
         cfg_ff.symbol_gap_ticks <= 8'd1;
         cfg_ff.letter_gap_ticks <= 8'd3;
         cfg_ff.word_gap_ticks   <= 8'd7;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_ACTIVE:     active_ff               <= csr_data[3:0];
            CSR_DOT:        cfg_ff.dot_ticks        <= csr_data[6:0];
            CSR_DASH:       cfg_ff.dash_ticks       <= csr_data[6:0];
            CSR_SYMBOL_GAP: cfg_ff.symbol_gap_ticks <= csr_data;
            CSR_LETTER_GAP: cfg_ff.letter_gap_ticks <= csr_data;
            CSR_WORD_GAP:   cfg_ff.word_gap_ticks   <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

### rtl/mcmb_ram.sv
`timescale 1ns / 1ps

module mcmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/mcmb_chan_unit.sv
`timescale 1ns / 1ps

module mcmb_chan_unit (
   input  logic [mcmb_pkg::CNTDN_W-1:0] countdown,
   input  logic [mcmb_pkg::ELEM_W-1:0]  elem,
   input  logic [mcmb_pkg::POS_W-1:0]   pos,
   input  logic [mcmb_pkg::CHAR_W-1:0]  chr,
   input  mcmb_pkg::cfg_type            cfg,
   output mcmb_pkg::chan_next_type      nxt
);
   import mcmb_pkg::*;

   logic [ENT_W-1:0] ent;
   logic [2:0]       len;
   logic [7:0]       bits;
   logic             is_dash;
   logic [8:0]       mark_sum;
   logic [7:0]       mark_load;
   logic [7:0]       gap_load;

   always_comb begin
      ent      = table_entry(chr);
      len      = code_len(ent);
      bits     = code_bits(ent);
      is_dash  = bits[elem];
      mark_sum = (is_dash ? {2'b00, cfg.dash_ticks} : {2'b00, cfg.dot_ticks})
                 + {1'b0, cfg.symbol_gap_ticks};
      mark_load = mark_sum[8] ? 8'hFF : mark_sum[7:0];
      gap_load  = cfg.letter_gap_ticks;

      nxt.countdown = countdown;
      nxt.elem      = elem;
      nxt.pos       = pos;
      nxt.pin_write = 1'b0;
      nxt.pin_level = 1'b0;

      if (countdown != '0) begin
         // pin drops once the symbol gap begins
         nxt.countdown = countdown - 1'b1;
         nxt.pin_write = (countdown == cfg.symbol_gap_ticks);
      end else if (chr == '0) begin
         // end of message: rewind, idle one tick
         nxt.pos  = '0;
         nxt.elem = '0;
      end else begin
         nxt.pin_write = 1'b1;
         if ({1'b0, elem} < {1'b0, len}) begin
            nxt.elem = elem + 1'b1;
            if (ent == SPACE_ENTRY) begin
               gap_load      = cfg.word_gap_ticks;
               nxt.countdown = (gap_load != '0) ? gap_load - 1'b1 : '0;
            end else begin
               nxt.pin_level = 1'b1;
               nxt.countdown = (mark_load != '0) ? mark_load - 1'b1 : '0;
            end
         end else begin
            // letter pause, advance to next character
            nxt.elem      = '0;
            nxt.pos       = (32'(pos) >= MSG_LEN - 1) ? '0 : pos + 1'b1;
            nxt.countdown = (gap_load != '0) ? gap_load - 1'b1 : '0;
         end
      end
   end

endmodule
